### rtl/kls_pkg.sv
// Package: shared types and constants for the k-th largest selector.
`default_nettype none
package kls_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RANK_W = 5;
  localparam int MAX_ELEMENTS = 8;

  localparam logic signed [SAMPLE_W-1:0] MIN_S16 = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] MAX_S16 = 16'sh7fff;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic [RANK_W-1:0]          rank;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] ranked_value;
    logic                       rank_error;
  } out_beat_t;

endpackage
`default_nettype wire

### rtl/kls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire [$clog2(DEPTH)-1:0]  wr_addr,
  input  wire [WIDTH-1:0]          wr_data,
  input  wire                      rd_en,
  input  wire [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/kth_largest_select.sv
// Top level: rank-th largest of a streamed set, selected by extraction passes over a RAM.
// A beat with last=0 gives no result. A beat with last=1 gives its result after P+1
// passes, N the set size and P = min(rank, N-rank-1); each pass reads every entry.
// An error result (bad rank or overflow) skips the passes; input stalls from the last
// beat until its result enters the output register. Reset empties the set.
`default_nettype none
module kth_largest_select #(
  parameter int MAX_ELEMENTS = kls_pkg::MAX_ELEMENTS
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  kls_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output kls_pkg::out_beat_t  out_data
);

  localparam int IW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int XW = (CW > kls_pkg::RANK_W) ? CW : kls_pkg::RANK_W;
  localparam int SW = kls_pkg::SAMPLE_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t               state;
  logic [CW-1:0]        count;
  logic                 overflow_seen;
  logic [MAX_ELEMENTS-1:0] taken;
  logic [IW-1:0]        scan_top;
  logic                 from_top;
  logic [XW-1:0]        passes_left;
  logic signed [SW-1:0] best;
  logic [IW-1:0]        best_idx;
  logic [IW-1:0]        issue_idx;
  logic                 issuing;
  logic                 rd_valid;
  logic [IW-1:0]        rd_idx;
  logic [SW-1:0]        rd_data;
  kls_pkg::out_beat_t   result;

  logic                 in_fire;
  logic                 full;
  logic [CW-1:0]        eff_count;
  logic                 set_error;
  logic                 start_top;
  logic [XW-1:0]        start_passes;
  logic signed [SW-1:0] rd_sample;
  logic                 cand;
  logic signed [SW-1:0] best_upd;
  logic [IW-1:0]        idx_upd;
  logic                 pass_end;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign full      = (count == CW'(MAX_ELEMENTS));
  assign eff_count = full ? count : count + CW'(1);
  assign set_error = overflow_seen || full
                     || (XW'(in_data.rank) >= XW'(eff_count));
  assign start_top = XW'(in_data.rank) < XW'(eff_count >> 1);
  assign start_passes = start_top ? XW'(in_data.rank)
                                  : XW'(eff_count) - XW'(in_data.rank) - XW'(1);

  kls_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_fire && !full),
    .wr_addr (count[IW-1:0]),
    .wr_data (in_data.sample),
    .rd_en   (issuing),
    .rd_addr (issue_idx),
    .rd_data (rd_data)
  );

  // Compare the entry just read against the running extreme; lower index wins ties.
  always_comb begin
    rd_sample = rd_data;
    cand = rd_valid && !taken[rd_idx]
           && (from_top ? (rd_sample >= best) : (rd_sample <= best));
    best_upd = cand ? rd_sample : best;
    idx_upd  = cand ? rd_idx : best_idx;
    pass_end = rd_valid && (rd_idx == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      overflow_seen <= 1'b0;
      taken         <= '0;
      issuing       <= 1'b0;
      rd_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      rd_valid <= issuing;
      rd_idx   <= issue_idx;
      if (issuing) begin
        if (issue_idx == '0) begin
          issuing <= 1'b0;
        end else begin
          issue_idx <= issue_idx - IW'(1);
        end
      end

      if (out_valid && out_ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_data.last) begin
              count         <= '0;
              overflow_seen <= 1'b0;
              taken         <= '0;
              if (set_error) begin
                result.ranked_value <= '0;
                result.rank_error   <= 1'b1;
                state               <= ST_FINISH;
              end else begin
                scan_top    <= IW'(eff_count - CW'(1));
                issue_idx   <= IW'(eff_count - CW'(1));
                issuing     <= 1'b1;
                from_top    <= start_top;
                passes_left <= start_passes;
                best        <= start_top ? kls_pkg::MIN_S16 : kls_pkg::MAX_S16;
                best_idx    <= '0;
                state       <= ST_SCAN;
              end
            end else if (full) begin
              overflow_seen <= 1'b1;
            end else begin
              count <= count + CW'(1);
            end
          end
        end
        ST_SCAN: begin
          if (pass_end && (passes_left != '0)) begin
            // Drop the extreme of this pass and start the next pass.
            taken[idx_upd] <= 1'b1;
            passes_left    <= passes_left - XW'(1);
            best           <= from_top ? kls_pkg::MIN_S16 : kls_pkg::MAX_S16;
            best_idx       <= '0;
            issue_idx      <= scan_top;
            issuing        <= 1'b1;
          end else begin
            best     <= best_upd;
            best_idx <= idx_upd;
            if (pass_end) begin
              result.ranked_value <= best_upd;
              result.rank_error   <= 1'b0;
              taken               <= '0;
              state               <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          // Hold the result until the output register is free.
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= result;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
